// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every rising clock edge outside of reset
`define ASSERT_RST(name_, clk_, rstn_, prop_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) prop_) \
    else $error("assertion failed");

// condition that must never hold outside of reset
`define ASSERT_NEVER(name_, clk_, rstn_, cond_) \
  `ASSERT_RST(name_, clk_, rstn_, !(cond_))

`else

`define ASSERT_RST(name_, clk_, rstn_, prop_)
`define ASSERT_NEVER(name_, clk_, rstn_, cond_)

`endif

`endif

// ----- rtl/core/ira_pkg.sv -----
// ----------------------------------------------------------------------------
// ira_pkg
// shared types and constants of the integer to radix ascii converter
// ----------------------------------------------------------------------------
package ira_pkg;

  // converted word width
  localparam int unsigned VALUE_WIDTH = 32;

  // power-of-two radices work on a word padded to a multiple of 3 and 4 bits
  localparam int unsigned SHIFT_WIDTH = ((VALUE_WIDTH + 11) / 12) * 12;
  // decimal digits needed for any value_width-bit magnitude
  localparam int unsigned DEC_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned BCD_WIDTH   = 4 * DEC_DIGITS;
  localparam int unsigned EMIT_WIDTH  = (SHIFT_WIDTH > BCD_WIDTH) ? SHIFT_WIDTH : BCD_WIDTH;
  localparam int unsigned LEFT_WIDTH  = $clog2(SHIFT_WIDTH + 1);
  localparam int unsigned CONV_WIDTH  = $clog2(VALUE_WIDTH + 1);

  localparam int unsigned DIGITS_BIN = SHIFT_WIDTH;
  localparam int unsigned DIGITS_OCT = SHIFT_WIDTH / 3;
  localparam int unsigned DIGITS_HEX = SHIFT_WIDTH / 4;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_UPPER = 7'h41;
  localparam logic [6:0] CH_BIN   = 7'h62;
  localparam logic [6:0] CH_OCT   = 7'h6f;
  localparam logic [6:0] CH_HEX   = 7'h78;
  localparam logic [6:0] CH_MINUS = 7'h2d;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_e;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  // classified conversion job
  typedef struct packed {
    val_t  mag;
    base_e base;
    logic  neg;
  } job_t;

  // one output character
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_t;

  function automatic logic [6:0] digit_char(input logic [3:0] dig);
    logic [6:0] code;
    if (dig < 4'd10) begin
      code = CH_ZERO + 7'(dig);
    end else begin
      code = CH_UPPER + 7'(dig) - 7'd10;
    end
    return code;
  endfunction

endpackage

// ----- rtl/core/ira_front.sv -----
// ----------------------------------------------------------------------------
// ira_front
// accepts input values, classifies sign and radix, queues conversion jobs
// ----------------------------------------------------------------------------
module ira_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic signed [31:0]  value_i,
  input  logic [1:0]          base_sel_i,
  output logic                job_valid_o,
  output ira_pkg::job_t       job_o,
  input  logic                job_take_i
);

  ira_pkg::val_t  pattern;
  ira_pkg::base_e base;
  ira_pkg::job_t  job_in;
  logic           is_neg;

  ira_pkg::job_t  mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push_ok, take_ok;

  // sign-extend or cut the 32-bit input to the working width
  if (ira_pkg::VALUE_WIDTH <= 32) begin : g_cut
    assign pattern = value_i[ira_pkg::VALUE_WIDTH-1:0];
  end else begin : g_ext
    assign pattern = {{(ira_pkg::VALUE_WIDTH-32){value_i[31]}}, value_i};
  end

  assign base   = ira_pkg::base_e'(base_sel_i);
  assign is_neg = pattern[ira_pkg::VALUE_WIDTH-1] && (base == ira_pkg::BASE_DEC);

  always_comb begin
    job_in.base = base;
    job_in.neg  = is_neg;
    // decimal negatives carry their magnitude, the most negative one included
    job_in.mag  = is_neg ? ira_pkg::val_t'(~pattern + ira_pkg::val_t'(1)) : pattern;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rd_ptr_q];
  assign push_ok     = push_i && !full_o;
  assign take_ok     = job_take_i && job_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (take_ok) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_ok && !take_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (take_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

// ----- rtl/core/ira_charq.sv -----
// ----------------------------------------------------------------------------
// ira_charq
// two-entry queue holding characters until the receiver pops them
// ----------------------------------------------------------------------------
module ira_charq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  ira_pkg::char_t char_i,
  output logic           empty_o,
  input  logic           pop_i,
  output ira_pkg::char_t char_o
);

  ira_pkg::char_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push_ok, pop_ok;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign char_o  = mem_q[rd_ptr_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_ok) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= char_i;
    end
  end

endmodule

// ----- rtl/core/ira_back.sv -----
// ----------------------------------------------------------------------------
// ira_back
// digit engine: prefix, double-dabble for decimal, msb-first digit emission
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ira_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  ira_pkg::job_t  job_i,
  output logic           job_take_o,
  output logic           out_push_o,
  output ira_pkg::char_t out_char_o,
  input  logic           out_full_i
);

  localparam int unsigned EW = ira_pkg::EMIT_WIDTH;
  localparam int unsigned VW = ira_pkg::VALUE_WIDTH;
  localparam int unsigned BW = ira_pkg::BCD_WIDTH;
  localparam int unsigned LW = ira_pkg::LEFT_WIDTH;
  localparam int unsigned CW = ira_pkg::CONV_WIDTH;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE0  = 3'd1;
  localparam logic [2:0] ST_PRE1  = 3'd2;
  localparam logic [2:0] ST_CONV  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]     state_q, state_d;
  ira_pkg::base_e base_q, base_d;
  logic           neg_q, neg_d;
  logic           seen_q, seen_d;
  logic [LW-1:0]  left_q, left_d;
  logic [CW-1:0]  conv_q, conv_d;
  ira_pkg::val_t  bin_q, bin_d;
  logic [BW-1:0]  bcd_q, bcd_d;
  logic [EW-1:0]  em_q, em_d;

  logic [BW-1:0]  bcd_adj;
  logic [3:0]     digit;
  logic [EW-1:0]  em_next;
  logic           final_digit;
  logic           emit;

  // add-3 correction on every bcd lane
  always_comb begin
    for (int i = 0; i < ira_pkg::DEC_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    case (base_q)
      ira_pkg::BASE_BIN: begin
        digit   = {3'b000, em_q[EW-1]};
        em_next = em_q << 1;
      end
      ira_pkg::BASE_OCT: begin
        digit   = {1'b0, em_q[EW-1 -: 3]};
        em_next = em_q << 3;
      end
      default: begin
        digit   = em_q[EW-1 -: 4];
        em_next = em_q << 4;
      end
    endcase
  end

  assign final_digit = (left_q == LW'(1));
  // leading zeros are skipped, the last digit always goes out
  assign emit = (digit != 4'd0) || seen_q || final_digit;

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    neg_d      = neg_q;
    seen_d     = seen_q;
    left_d     = left_q;
    conv_d     = conv_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    em_d       = em_q;
    job_take_o = 1'b0;
    out_push_o = 1'b0;
    out_char_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_take_o = 1'b1;
          base_d     = job_i.base;
          neg_d      = job_i.neg;
          seen_d     = 1'b0;
          bin_d      = job_i.mag;
          bcd_d      = '0;
          conv_d     = CW'(VW);
          em_d       = EW'(job_i.mag) << (EW - ira_pkg::SHIFT_WIDTH);
          case (job_i.base)
            ira_pkg::BASE_BIN: left_d = LW'(ira_pkg::DIGITS_BIN);
            ira_pkg::BASE_OCT: left_d = LW'(ira_pkg::DIGITS_OCT);
            default:           left_d = LW'(ira_pkg::DIGITS_HEX);
          endcase
          if (job_i.base == ira_pkg::BASE_DEC && !job_i.neg) begin
            state_d = ST_CONV;
          end else begin
            state_d = ST_PRE0;
          end
        end
      end

      ST_PRE0: begin
        out_char_o.code = (base_q == ira_pkg::BASE_DEC) ? ira_pkg::CH_MINUS : ira_pkg::CH_ZERO;
        out_char_o.last = 1'b0;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = (base_q == ira_pkg::BASE_DEC) ? ST_CONV : ST_PRE1;
        end
      end

      ST_PRE1: begin
        case (base_q)
          ira_pkg::BASE_BIN: out_char_o.code = ira_pkg::CH_BIN;
          ira_pkg::BASE_OCT: out_char_o.code = ira_pkg::CH_OCT;
          default:           out_char_o.code = ira_pkg::CH_HEX;
        endcase
        out_char_o.last = 1'b0;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = ST_DIGIT;
        end
      end

      ST_CONV: begin
        if (conv_q == '0) begin
          em_d    = EW'(bcd_q) << (EW - BW);
          left_d  = LW'(ira_pkg::DEC_DIGITS);
          state_d = ST_DIGIT;
        end else begin
          bcd_d  = {bcd_adj[BW-2:0], bin_q[VW-1]};
          bin_d  = bin_q << 1;
          conv_d = conv_q - CW'(1);
        end
      end

      ST_DIGIT: begin
        out_char_o.code = ira_pkg::digit_char(digit);
        out_char_o.last = final_digit;
        if (!emit || !out_full_i) begin
          out_push_o = emit;
          em_d       = em_next;
          left_d     = left_q - LW'(1);
          seen_d     = seen_q || (digit != 4'd0);
          if (final_digit) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    neg_q  <= neg_d;
    seen_q <= seen_d;
    left_q <= left_d;
    conv_q <= conv_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    em_q   <= em_d;
  end

  `ASSERT_RST(a_digit_left, clk_i, rst_ni, (state_q == ST_DIGIT) |-> (left_q != '0))
  `ASSERT_RST(a_take_busy, clk_i, rst_ni, job_take_o |=> (state_q != ST_IDLE))
  `ASSERT_RST(a_bcd_range, clk_i, rst_ni, (state_q == ST_DIGIT && base_q == ira_pkg::BASE_DEC) |-> (em_q[EW-1 -: 4] <= 4'd9))
  `ASSERT_NEVER(a_dec_no_letter, clk_i, rst_ni, (state_q == ST_PRE1 && base_q == ira_pkg::BASE_DEC))

endmodule

// ----- rtl/core/integer_to_radix_ascii.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// signed integer to ascii text in binary, octal, decimal or hex
// ----------------------------------------------------------------------------
// input queue: a transaction (value_i, base_sel_i) is taken on a clock edge
// with push high and full low; up to two values wait ahead of the digit engine.
// output queue: while empty is low, char_code_o/last_o show the oldest
// character; pop high takes it. last_o marks the final character of a value.
// text is 0b/0o/0x plus digits, or an optional '-' plus decimal digits.
// the digit engine takes one value at a time and steps, per value, through:
//   binary, octal, hex: a load step, two prefix characters, then one digit
//   step for each digit of the 36-bit padded word, leading zeros included
//   decimal: a load step, an optional '-', shift-add-3 conversion of the
//   32-bit magnitude, then one digit step per digit of the 10-digit result
// with the engine idle, a prefixed value passes the job queue and the load
// step before its first character is written; empty drops as it is written.
// a stalled receiver fills the two-entry output queue, and the engine waits
// at its next character; input is still taken until the job queue is full.
// reset empties both queues and returns the engine to idle.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] value_i,
  input  logic [1:0]         base_sel_i,
  output logic               empty,
  input  logic               pop,
  output logic [6:0]         char_code_o,
  output logic               last_o
);

  logic           job_valid;
  logic           job_take;
  ira_pkg::job_t  job;
  logic           out_push;
  logic           out_full;
  ira_pkg::char_t out_char;
  ira_pkg::char_t head_char;

  ira_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .value_i     (value_i),
    .base_sel_i  (base_sel_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  ira_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .out_push_o  (out_push),
    .out_char_o  (out_char),
    .out_full_i  (out_full)
  );

  ira_charq u_charq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .full_o  (out_full),
    .char_i  (out_char),
    .empty_o (empty),
    .pop_i   (pop),
    .char_o  (head_char)
  );

  assign char_code_o = head_char.code;
  assign last_o      = head_char.last;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the integer to radix ascii converter
// ----------------------------------------------------------------------------
// a queue of conversion requests is filled up front: the extremes of every
// radix, +-10, 0xA, 8 and 2, then a random mix of wide, small, negative,
// single-bit, low-mask and shifted values. a driver pushes them with random
// gaps and one or more full drains. a receiver pops with random stalls. every
// accepted value is spelled out by an in-bench text generator, and each popped
// character is compared, code and last flag, with the oldest owed character.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned RANDOM_ITEMS = 460;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 60;

  typedef struct {
    logic [31:0]    value;
    ira_pkg::base_e base;
    bit             drain_first;
    bit             calm;
  } conv_req_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               push       = 1'b0;
  logic               full;
  logic signed [31:0] value_i    = '0;
  logic [1:0]         base_sel_i = '0;
  logic               empty;
  logic               pop        = 1'b0;
  logic [6:0]         char_code_o;
  logic               last_o;

  conv_req_t      req_backlog [$];
  ira_pkg::char_t text_due [$];
  conv_req_t      req;
  ira_pkg::char_t due;
  logic           took_item = 1'b0;
  logic           rx_calm   = 1'b0;
  int unsigned    gap_left   = 0;
  int unsigned    stall_left = 0;
  int unsigned    mismatches = 0;
  int unsigned    chars_seen = 0;
  int unsigned    base_hits [4] = '{0, 0, 0, 0};

  integer_to_radix_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .base_sel_i  (base_sel_i),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  always #6 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic void queue_item(input logic [31:0] value, input ira_pkg::base_e base,
                                     input bit drain_first, input bit calm);
    conv_req_t r;
    r.value       = value;
    r.base        = base;
    r.drain_first = drain_first;
    r.calm        = calm;
    req_backlog.push_back(r);
  endfunction

  // spells one value as text and appends its characters to the owed list
  function automatic void spell_value(input logic [31:0] value, input ira_pkg::base_e base);
    logic [31:0]    mag;
    logic [31:0]    radix;
    logic [3:0]     digs [$];
    logic [6:0]     glyphs [$];
    ira_pkg::char_t ch;
    mag = value;
    case (base)
      ira_pkg::BASE_BIN: begin
        radix = 2;
        glyphs.push_back(ira_pkg::CH_ZERO);
        glyphs.push_back(ira_pkg::CH_BIN);
      end
      ira_pkg::BASE_OCT: begin
        radix = 8;
        glyphs.push_back(ira_pkg::CH_ZERO);
        glyphs.push_back(ira_pkg::CH_OCT);
      end
      ira_pkg::BASE_DEC: begin
        radix = 10;
        // most negative value wraps to itself, read unsigned it is 2^31
        if (value[31]) begin
          glyphs.push_back(ira_pkg::CH_MINUS);
          mag = 32'd0 - value;
        end
      end
      default: begin
        radix = 16;
        glyphs.push_back(ira_pkg::CH_ZERO);
        glyphs.push_back(ira_pkg::CH_HEX);
      end
    endcase
    do begin
      digs.push_front(4'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    foreach (digs[i]) begin
      glyphs.push_back(digs[i] < 4'd10 ? ira_pkg::CH_ZERO + 7'(digs[i])
                                       : ira_pkg::CH_UPPER + 7'(digs[i] - 4'd10));
    end
    foreach (glyphs[i]) begin
      ch.code = glyphs[i];
      ch.last = (i == glyphs.size() - 1);
      text_due.push_back(ch);
    end
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!push || took_item)) begin
      if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (req_backlog.size() == 0 ||
                   (req_backlog[0].drain_first && text_due.size() != 0)) begin
        push <= 1'b0;
      end else begin
        req = req_backlog.pop_front();
        value_i    <= req.value;
        base_sel_i <= req.base;
        push       <= 1'b1;
        rx_calm    <= req.calm;
        gap_left   = pick_gap(req.calm);
      end
    end
  end

  // receiver with random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      stall_left = pick_gap(rx_calm);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    took_item <= rst_ni && push && !full;
    if (rst_ni && push && !full) begin
      spell_value(value_i, ira_pkg::base_e'(base_sel_i));
      base_hits[base_sel_i]++;
    end
    if (rst_ni && pop && !empty) begin
      chars_seen++;
      if (text_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char: code 0x%02h last %0b", char_code_o, last_o);
      end else begin
        due = text_due.pop_front();
        if (char_code_o !== due.code || last_o !== due.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char %0d: code exp 0x%02h got 0x%02h, last exp %0b got %0b",
                     chars_seen, due.code, char_code_o, due.last, last_o);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) stuck = 0;
      else stuck++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    logic [31:0]    v;
    ira_pkg::base_e b;
    // extremes in every radix
    for (int k = 0; k < 4; k++) begin
      b = ira_pkg::base_e'(k);
      queue_item(32'h0000_0000, b, 1'b0, 1'b0);
      queue_item(32'h0000_0001, b, 1'b0, 1'b0);
      queue_item(32'hFFFF_FFFF, b, 1'b0, 1'b0);
      queue_item(32'h7FFF_FFFF, b, 1'b0, 1'b0);
      queue_item(32'h8000_0000, b, 1'b0, 1'b0);
    end
    queue_item(32'd10, ira_pkg::BASE_DEC, 1'b0, 1'b0);
    queue_item(-32'sd10, ira_pkg::BASE_DEC, 1'b0, 1'b0);
    queue_item(32'hA, ira_pkg::BASE_HEX, 1'b0, 1'b0);
    queue_item(32'd8, ira_pkg::BASE_OCT, 1'b0, 1'b0);
    queue_item(32'd2, ira_pkg::BASE_BIN, 1'b0, 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 6))
        0, 1:    v = $urandom();
        2:       v = $urandom_range(0, 40);
        3:       v = 32'd0 - $urandom_range(1, 40);
        4:       v = 32'h1 << $urandom_range(0, 31);
        5:       v = (32'h1 << $urandom_range(0, 31)) - 32'd1;
        default: v = $urandom() >> $urandom_range(0, 31);
      endcase
      b = ira_pkg::base_e'($urandom_range(0, 3));
      queue_item(v, b, i == 0 || i == 230, i >= 300 && i < 360);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_backlog.size() != 0 || push) @(negedge clk_i);
    while (text_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("converted %0d values: %0d binary, %0d octal, %0d decimal, %0d hex",
             base_hits[0] + base_hits[1] + base_hits[2] + base_hits[3],
             base_hits[0], base_hits[1], base_hits[2], base_hits[3]);
    $display("checked %0d characters, %0d mismatches", chars_seen, mismatches);
    if (mismatches == 0 && text_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
